// ===== design/hsv_to_rgb_converter_defines.svh =====
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Shared concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

`ifndef SYNTHESIS
`define HSV2RGB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HSV2RGB_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define HSV2RGB_ASSERT(label, clk, rst, prop, msg)
`define HSV2RGB_ASSERT_NORST(label, clk, prop, msg)
`endif

`endif

// ===== design/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Fixed-point formats, pipeline payload types and sextant codes.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int FRACTION_BITS = 12;
  localparam int HUE_W         = FRACTION_BITS;
  localparam int LEVEL_W       = FRACTION_BITS + 1;
  localparam int H6_W          = FRACTION_BITS + 3;
  localparam int SEXT_W        = 3;
  localparam int PROD_W        = 2 * FRACTION_BITS + 1;
  localparam int SPAN_W        = 3 * FRACTION_BITS + 1;
  localparam int CH_W          = 8;
  localparam int SUM_W         = CH_W + 1;

  localparam logic [LEVEL_W-1:0] ONE    = LEVEL_W'(1) << FRACTION_BITS;
  localparam logic [CH_W-1:0]    CH_MAX = '1;

  localparam logic [SEXT_W-1:0] SEXT_RED_YELLOW    = 3'd0;
  localparam logic [SEXT_W-1:0] SEXT_YELLOW_GREEN  = 3'd1;
  localparam logic [SEXT_W-1:0] SEXT_GREEN_CYAN    = 3'd2;
  localparam logic [SEXT_W-1:0] SEXT_CYAN_BLUE     = 3'd3;
  localparam logic [SEXT_W-1:0] SEXT_BLUE_MAGENTA  = 3'd4;
  localparam logic [SEXT_W-1:0] SEXT_MAGENTA_RED   = 3'd5;

  typedef struct packed {
    logic [SEXT_W-1:0]  sextant;
    logic [LEVEL_W-1:0] omd;
    logic [LEVEL_W-1:0] level;
    logic [PROD_W-1:0]  prod;
  } front_t;

  typedef struct packed {
    logic [SEXT_W-1:0] sextant;
    logic [CH_W-1:0]   m;
    logic [SUM_W-1:0]  c0;
    logic [SPAN_W-1:0] px;
  } scale_t;

endpackage

// ===== design/hsv2rgb_if.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter channel interfaces
// Valid/ready channels for the HSV input and the RGB output.
// ----------------------------------------------------------------------------
interface hsv2rgb_in_if;
  logic                               valid;
  logic                               ready;
  logic [hsv2rgb_pkg::HUE_W-1:0]      hue;
  logic [hsv2rgb_pkg::LEVEL_W-1:0]    saturation;
  logic [hsv2rgb_pkg::LEVEL_W-1:0]    brightness;

  modport source(output valid, hue, saturation, brightness, input ready);
  modport sink(input valid, hue, saturation, brightness, output ready);
endinterface

interface hsv2rgb_out_if;
  logic                            valid;
  logic                            ready;
  logic [hsv2rgb_pkg::CH_W-1:0]    red;
  logic [hsv2rgb_pkg::CH_W-1:0]    green;
  logic [hsv2rgb_pkg::CH_W-1:0]    blue;

  modport source(output valid, red, green, blue, input ready);
  modport sink(input valid, red, green, blue, output ready);
endinterface

// ===== design/hsv2rgb_front.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter front stages
// Clamps the levels, splits hue into sextant and ramp, then forms chroma.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_defines.svh"

module hsv2rgb_front (
  input  logic                 clk,
  input  logic                 rst,
  hsv2rgb_in_if.sink           hsv,
  output logic                 valid,
  input  logic                 ready,
  output hsv2rgb_pkg::front_t  data
);

  logic [hsv2rgb_pkg::H6_W-1:0]          h6;
  logic [hsv2rgb_pkg::FRACTION_BITS-1:0] low;
  logic [hsv2rgb_pkg::SEXT_W-1:0]        sextant_c;
  logic [hsv2rgb_pkg::LEVEL_W-1:0]       omd_c;
  logic [hsv2rgb_pkg::LEVEL_W-1:0]       sat_c;
  logic [hsv2rgb_pkg::LEVEL_W-1:0]       bright_c;
  logic [2*hsv2rgb_pkg::LEVEL_W-1:0]     prod_full;

  logic                            v1;
  logic                            ready1;
  logic                            ready2;
  logic [hsv2rgb_pkg::SEXT_W-1:0]  sextant1;
  logic [hsv2rgb_pkg::LEVEL_W-1:0] omd1;
  logic [hsv2rgb_pkg::LEVEL_W-1:0] sat1;
  logic [hsv2rgb_pkg::LEVEL_W-1:0] bright1;

  always_comb begin
    h6 = (hsv2rgb_pkg::H6_W'(hsv.hue) << 2) + (hsv2rgb_pkg::H6_W'(hsv.hue) << 1);
    low = h6[hsv2rgb_pkg::FRACTION_BITS-1:0];
    sextant_c = h6[hsv2rgb_pkg::H6_W-1:hsv2rgb_pkg::FRACTION_BITS];
    if (sextant_c[0]) begin
      omd_c = hsv2rgb_pkg::ONE - hsv2rgb_pkg::LEVEL_W'(low);
    end else begin
      omd_c = hsv2rgb_pkg::LEVEL_W'(low);
    end
    sat_c = (hsv.saturation > hsv2rgb_pkg::ONE) ? hsv2rgb_pkg::ONE : hsv.saturation;
    bright_c = (hsv.brightness > hsv2rgb_pkg::ONE) ? hsv2rgb_pkg::ONE : hsv.brightness;
    prod_full = bright1 * sat1;
  end

  assign ready2 = !valid || ready;
  assign ready1 = !v1 || ready2;
  assign hsv.ready = ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= hsv.valid;
    end
    if (ready1 && hsv.valid) begin
      sextant1 <= sextant_c;
      omd1 <= omd_c;
      sat1 <= sat_c;
      bright1 <= bright_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready2) begin
      valid <= v1;
    end
    if (ready2 && v1) begin
      data.sextant <= sextant1;
      data.omd <= omd1;
      data.level <= bright1;
      data.prod <= prod_full[hsv2rgb_pkg::PROD_W-1:0];
    end
  end

  `HSV2RGB_ASSERT(a_front_ranges, clk, rst, v1 |-> (sextant1 <= hsv2rgb_pkg::SEXT_MAGENTA_RED && omd1 <= hsv2rgb_pkg::ONE && sat1 <= hsv2rgb_pkg::ONE), "front stage value out of range")

endmodule

// ===== design/hsv2rgb_scale.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter scaling stage
// Scales minimum and chroma to 0..255 and forms the ramp product.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_defines.svh"

module hsv2rgb_scale (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hsv2rgb_pkg::front_t  in_data,
  output logic                 valid,
  input  logic                 ready,
  output hsv2rgb_pkg::scale_t  data
);

  localparam int MUL_W = hsv2rgb_pkg::PROD_W + hsv2rgb_pkg::CH_W;
  localparam int SH    = 2 * hsv2rgb_pkg::FRACTION_BITS;

  logic [hsv2rgb_pkg::PROD_W-1:0]                       mnum;
  logic [MUL_W-1:0]                                     m_scaled;
  logic [MUL_W-1:0]                                     c_scaled;
  logic [hsv2rgb_pkg::SUM_W-1:0]                        m9;
  logic [hsv2rgb_pkg::PROD_W+hsv2rgb_pkg::LEVEL_W-1:0]  px_full;

  always_comb begin
    mnum = {in_data.level, {hsv2rgb_pkg::FRACTION_BITS{1'b0}}} - in_data.prod;
    m_scaled = (MUL_W'(mnum) << hsv2rgb_pkg::CH_W) - MUL_W'(mnum) + (MUL_W'(1) << (SH - 1));
    c_scaled = (MUL_W'(in_data.prod) << hsv2rgb_pkg::CH_W) - MUL_W'(in_data.prod)
               + (MUL_W'(1) << (SH - 1));
    m9 = m_scaled[MUL_W-1:SH];
    px_full = in_data.prod * in_data.omd;
  end

  assign in_ready = !valid || ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      data.sextant <= in_data.sextant;
      data.m <= (m9 > hsv2rgb_pkg::SUM_W'(hsv2rgb_pkg::CH_MAX)) ? hsv2rgb_pkg::CH_MAX
                                                                : m9[hsv2rgb_pkg::CH_W-1:0];
      data.c0 <= c_scaled[MUL_W-1:SH];
      data.px <= px_full[hsv2rgb_pkg::SPAN_W-1:0];
    end
  end

  `HSV2RGB_ASSERT(a_scale_chroma, clk, rst, valid |-> (data.c0 <= hsv2rgb_pkg::SUM_W'(hsv2rgb_pkg::CH_MAX)), "scaled chroma above full scale")

endmodule

// ===== design/hsv2rgb_mix.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter output stage
// Scales the ramp term, saturates the sums and routes channels by sextant.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_defines.svh"

module hsv2rgb_mix (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  hsv2rgb_pkg::scale_t  in_data,
  hsv2rgb_out_if.source        rgb
);

  localparam int XMUL_W = hsv2rgb_pkg::SPAN_W + hsv2rgb_pkg::CH_W;
  localparam int XSH    = 3 * hsv2rgb_pkg::FRACTION_BITS;

  logic [XMUL_W-1:0]              x_scaled;
  logic [hsv2rgb_pkg::SUM_W-1:0]  x0;
  logic [hsv2rgb_pkg::SUM_W:0]    c_sum;
  logic [hsv2rgb_pkg::SUM_W:0]    x_sum;
  logic [hsv2rgb_pkg::CH_W-1:0]   c_ch;
  logic [hsv2rgb_pkg::CH_W-1:0]   x_ch;
  logic [hsv2rgb_pkg::CH_W-1:0]   m_ch;
  logic [hsv2rgb_pkg::CH_W-1:0]   red_next;
  logic [hsv2rgb_pkg::CH_W-1:0]   green_next;
  logic [hsv2rgb_pkg::CH_W-1:0]   blue_next;

  logic                           valid;
  logic [hsv2rgb_pkg::CH_W-1:0]   red;
  logic [hsv2rgb_pkg::CH_W-1:0]   green;
  logic [hsv2rgb_pkg::CH_W-1:0]   blue;

  always_comb begin
    x_scaled = (XMUL_W'(in_data.px) << hsv2rgb_pkg::CH_W) - XMUL_W'(in_data.px)
               + (XMUL_W'(1) << (XSH - 1));
    x0 = x_scaled[XMUL_W-1:XSH];
    m_ch = in_data.m;
    c_sum = (hsv2rgb_pkg::SUM_W+1)'(in_data.m) + (hsv2rgb_pkg::SUM_W+1)'(in_data.c0);
    x_sum = (hsv2rgb_pkg::SUM_W+1)'(in_data.m) + (hsv2rgb_pkg::SUM_W+1)'(x0);
    c_ch = (c_sum > (hsv2rgb_pkg::SUM_W+1)'(hsv2rgb_pkg::CH_MAX)) ? hsv2rgb_pkg::CH_MAX
                                                                   : c_sum[hsv2rgb_pkg::CH_W-1:0];
    x_ch = (x_sum > (hsv2rgb_pkg::SUM_W+1)'(hsv2rgb_pkg::CH_MAX)) ? hsv2rgb_pkg::CH_MAX
                                                                   : x_sum[hsv2rgb_pkg::CH_W-1:0];
    case (in_data.sextant)
      hsv2rgb_pkg::SEXT_RED_YELLOW: begin
        red_next = c_ch;
        green_next = x_ch;
        blue_next = m_ch;
      end
      hsv2rgb_pkg::SEXT_YELLOW_GREEN: begin
        red_next = x_ch;
        green_next = c_ch;
        blue_next = m_ch;
      end
      hsv2rgb_pkg::SEXT_GREEN_CYAN: begin
        red_next = m_ch;
        green_next = c_ch;
        blue_next = x_ch;
      end
      hsv2rgb_pkg::SEXT_CYAN_BLUE: begin
        red_next = m_ch;
        green_next = x_ch;
        blue_next = c_ch;
      end
      hsv2rgb_pkg::SEXT_BLUE_MAGENTA: begin
        red_next = x_ch;
        green_next = m_ch;
        blue_next = c_ch;
      end
      default: begin
        red_next = c_ch;
        green_next = m_ch;
        blue_next = x_ch;
      end
    endcase
  end

  assign in_ready = !valid || rgb.ready;
  assign rgb.valid = valid;
  assign rgb.red = red;
  assign rgb.green = green;
  assign rgb.blue = blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      red <= red_next;
      green <= green_next;
      blue <= blue_next;
    end
  end

  `HSV2RGB_ASSERT_NORST(a_mix_reset, clk, rst |=> !valid, "output valid after reset")
  `HSV2RGB_ASSERT(a_mix_load, clk, rst, (in_valid && in_ready) |=> valid, "accepted transaction not presented")

endmodule

// ===== design/hsv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Fixed-point hue, saturation and brightness to 8-bit red, green and blue.
// ----------------------------------------------------------------------------
// The hsv channel takes one transaction of hue (12-bit fraction of a turn),
// saturation and brightness (0 to 4096 for 0 to 1; larger values clamp to
// full). The rgb channel returns one transaction of red, green and blue.
// Both channels use valid/ready; a transaction moves when both are high.
// The datapath is a four-stage pipeline: input clamp and hue split,
// chroma multiply, scaling with the ramp multiply, then channel routing into
// the output register, which presents each result on rgb. One transaction per
// cycle is sustained while rgb.ready stays high.
// Each stage holds its own valid bit and loads whenever it is empty or the
// next stage loads, so a stall on rgb fills the empty stages first and then
// deasserts hsv.ready; nothing is dropped or repeated.
// Synchronous reset clears every stage valid bit; data registers are not
// cleared.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
  input  logic           clk,
  input  logic           rst,
  hsv2rgb_in_if.sink     hsv,
  hsv2rgb_out_if.source  rgb
);

  logic                 front_valid;
  logic                 front_ready;
  hsv2rgb_pkg::front_t  front_data;
  logic                 scale_valid;
  logic                 scale_ready;
  hsv2rgb_pkg::scale_t  scale_data;

  hsv2rgb_front u_front (
    .clk   (clk),
    .rst   (rst),
    .hsv   (hsv),
    .valid (front_valid),
    .ready (front_ready),
    .data  (front_data)
  );

  hsv2rgb_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .in_valid (front_valid),
    .in_ready (front_ready),
    .in_data  (front_data),
    .valid    (scale_valid),
    .ready    (scale_ready),
    .data     (scale_data)
  );

  hsv2rgb_mix u_mix (
    .clk      (clk),
    .rst      (rst),
    .in_valid (scale_valid),
    .in_ready (scale_ready),
    .in_data  (scale_data),
    .rgb      (rgb)
  );

endmodule
